[design/twirl_coordinate_warp_defines.svh]
// Assertion macros for the twirl coordinate warp checker.
// Expects signals named clk and rst in the scope that uses them.
`ifndef TWIRL_COORDINATE_WARP_DEFINES_SVH
`define TWIRL_COORDINATE_WARP_DEFINES_SVH

// Checked only out of reset.
`define TWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define TWC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/twc_pkg.sv]
// Shared types and constants for the twirl coordinate warp.
// No dependencies.
package twc_pkg;

  localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
  localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
  localparam logic signed [31:0] Q28_GAIN    = 32'sd163008218;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_RADIUS       = 3'd4,
    REG_TWIST_ANGLE  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               in_radius;
  } front_carry_t;

  typedef struct packed {
    front_carry_t fc;
    logic [16:0]  ratio;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t data;
  } q_push_t;

  typedef struct packed {
    logic  avail;
    qent_t data;
  } q_head_t;

  typedef struct packed {
    front_carry_t fc;
    logic         neg;
  } back_carry_t;

  // atan(2^-i) in Q.28
  function automatic logic signed [31:0] atan_q28(input int i);
    logic signed [31:0] r;
    case (i)
      0:  r = 32'sd210828714;
      1:  r = 32'sd124459457;
      2:  r = 32'sd65760959;
      3:  r = 32'sd33381290;
      4:  r = 32'sd16755422;
      5:  r = 32'sd8385879;
      6:  r = 32'sd4193963;
      7:  r = 32'sd2097109;
      8:  r = 32'sd1048571;
      9:  r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

[design/twc_if.sv]
// Valid/ready channel interfaces for pixel requests and results.
// No dependencies.
interface twc_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface twc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] source_x;
  logic [11:0] source_y;
  logic        was_twisted;
  modport source (output valid, source_x, source_y, was_twisted, input ready);
  modport sink (input valid, source_x, source_y, was_twisted, output ready);
endinterface

[design/twc_front.sv]
// Front pipeline: offset from center, distance by square root, radius test, ratio.
// Depends on twc_pkg and twc_in_if.
module twc_front (
  input  logic              clk,
  input  logic              rst,
  twc_in_if.sink            pix_in,
  input  logic [15:0]       center_x,
  input  logic [15:0]       center_y,
  input  logic [15:0]       radius,
  input  logic              q_full,
  output twc_pkg::q_push_t  q_wr
);
  localparam int SQ_STEPS = 17;
  localparam int DV_STEPS = 17;
  localparam int ST_PREP  = 3 + SQ_STEPS;
  localparam int DEPTH    = ST_PREP + 1 + DV_STEPS;

  logic                  adv;
  logic [DEPTH-1:0]      vld;
  twc_pkg::front_carry_t car [DEPTH];
  twc_pkg::front_carry_t entry;
  twc_pkg::front_carry_t prep;
  logic signed [33:0]    dxe, dye;
  logic [33:0]           sq_x, sq_y, sq_sum;
  logic [34:0]           sq_rem  [SQ_STEPS+1];
  logic [16:0]           sq_root [SQ_STEPS+1];
  logic [16:0]           dv_rem  [DV_STEPS+1];
  logic [16:0]           dv_quo  [DV_STEPS+1];
  logic [16:0]           dist_q4;
  logic                  in_rad;

  assign adv          = !vld[DEPTH-1] || !q_full;
  assign pix_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], pix_in.valid};
    end
  end

  always_comb begin
    entry.pixel_x   = pix_in.pixel_x;
    entry.pixel_y   = pix_in.pixel_y;
    entry.dx        = $signed({1'b0, pix_in.pixel_x, 4'b0000}) - $signed({1'b0, center_x});
    entry.dy        = $signed({1'b0, pix_in.pixel_y, 4'b0000}) - $signed({1'b0, center_y});
    entry.in_radius = 1'b0;
  end

  assign dxe = 34'(car[0].dx);
  assign dye = 34'(car[0].dy);

  always_ff @(posedge clk) begin
    if (adv) begin
      car[0] <= entry;
      sq_x   <= unsigned'(dxe * dxe);
      sq_y   <= unsigned'(dye * dye);
      sq_sum <= sq_x + sq_y;
    end
  end

  assign sq_rem[0]  = {1'b0, sq_sum};
  assign sq_root[0] = '0;

  // one root bit per stage, most significant first
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - g;
    logic [34:0] cand;
    assign cand = (35'({sq_root[g], 1'b0}) << B) + (35'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_rem[g] >= cand) begin
          sq_rem[g+1]  <= sq_rem[g] - cand;
          sq_root[g+1] <= sq_root[g] | (17'd1 << B);
        end else begin
          sq_rem[g+1]  <= sq_rem[g];
          sq_root[g+1] <= sq_root[g];
        end
      end
    end
  end

  assign dist_q4 = sq_root[SQ_STEPS];
  assign in_rad  = (radius != 16'd0) && (dist_q4 < {1'b0, radius});

  always_comb begin
    prep           = car[ST_PREP-1];
    prep.in_radius = in_rad;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= in_rad ? ({1'b0, radius} - dist_q4) : '0;
      dv_quo[0] <= '0;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv) begin
        car[k] <= (k == ST_PREP) ? prep : car[k-1];
      end
    end
  end

  // restoring division (radius - dist) * 2^16 / radius, one quotient bit per stage
  for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
    logic [16:0] val;
    if (j == 0) begin : g_first
      assign val = dv_rem[j];
    end else begin : g_rest
      assign val = {dv_rem[j][15:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (val >= {1'b0, radius}) begin
          dv_rem[j+1] <= val - {1'b0, radius};
          dv_quo[j+1] <= dv_quo[j] | (17'd1 << (DV_STEPS - 1 - j));
        end else begin
          dv_rem[j+1] <= val;
          dv_quo[j+1] <= dv_quo[j];
        end
      end
    end
  end

  always_comb begin
    q_wr.push       = vld[DEPTH-1] && !q_full;
    q_wr.data.fc    = car[DEPTH-1];
    q_wr.data.ratio = dv_quo[DV_STEPS];
  end

endmodule

[design/twc_queue.sv]
// Short queue between front and back pipelines.
// Depends on twc_pkg.
module twc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  twc_pkg::q_push_t wr,
  input  logic             pop,
  output logic             full,
  output twc_pkg::q_head_t head
);
  localparam int AW = $clog2(DEPTH);

  twc_pkg::qent_t  mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;

  assign full       = (count == (AW+1)'(DEPTH));
  assign head.avail = (count != '0);
  assign head.data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/twc_back.sv]
// Back pipeline: twist angle, range reduction, CORDIC, rotation, round and clamp.
// Depends on twc_pkg and twc_out_if.
module twc_back #(
  parameter int unsigned MAX_DIM      = 4096,
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  twc_pkg::q_head_t   head,
  output logic               pop,
  input  logic [12:0]        image_width,
  input  logic [12:0]        image_height,
  input  logic [15:0]        center_x,
  input  logic [15:0]        center_y,
  input  logic signed [16:0] twist_angle,
  twc_out_if.source          pix_out
);
  localparam int I        = int'(CORDIC_ITERS);
  localparam int ST_FOLD  = 6;
  localparam int ST_Q14   = 7 + I;
  localparam int ST_MUL   = ST_Q14 + 1;
  localparam int ST_XY    = ST_MUL + 1;
  localparam int DEPTH    = ST_XY + 2;

  logic                 adv;
  logic [DEPTH-1:0]     vld;
  twc_pkg::back_carry_t car [DEPTH];
  twc_pkg::back_carry_t entry, fold;
  logic [33:0]          pp;
  logic [16:0]          p2;
  logic [16:0]          amag;
  logic [33:0]          prod;
  logic [33:0]          prod_rnd;
  logic signed [17:0]   th;
  logic signed [33:0]   t_r [4];
  logic signed [33:0]   zf;
  logic                 negf;
  logic signed [31:0]   cxr [I+1];
  logic signed [31:0]   cyr [I+1];
  logic signed [31:0]   czr [I+1];
  logic signed [15:0]   cos_q, sin_q;
  logic signed [32:0]   m_dxc, m_dys, m_dxs, m_dyc;
  logic signed [34:0]   pos_x, pos_y;
  logic [11:0]          out_x, out_y;
  logic                 out_tw;

  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v, input logic neg);
    logic signed [31:0] s;
    logic signed [31:0] r;
    s = v + 32'sd8192;
    r = s >>> 14;
    if (r > 32'sd16384) begin
      r = 32'sd16384;
    end else if (r < -32'sd16384) begin
      r = -32'sd16384;
    end
    return neg ? 16'(-r) : 16'(r);
  endfunction

  function automatic logic [11:0] round_clamp(input logic signed [34:0] v,
                                               input logic [12:0] dim);
    logic [17:0] lim;
    logic [34:0] rr;
    logic [34:0] top;
    if (dim == 13'd0) begin
      lim = 18'd1;
    end else if (18'(dim) > 18'(MAX_DIM)) begin
      lim = 18'(MAX_DIM);
    end else begin
      lim = 18'(dim);
    end
    top = 35'(lim - 18'd1);
    rr  = unsigned'(v + 35'sd131072) >> 18;
    if (v[34]) begin
      rr = '0;
    end else if (rr > top) begin
      rr = top;
    end
    return rr[11:0];
  endfunction

  assign adv = !vld[DEPTH-1] || pix_out.ready;
  assign pop = head.avail && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], head.avail};
    end
  end

  always_comb begin
    entry.fc  = head.data.fc;
    entry.neg = 1'b0;
  end

  assign pp       = 34'(head.data.ratio) * 34'(head.data.ratio);
  assign amag     = twist_angle[16] ? 17'(-twist_angle) : 17'(twist_angle);
  assign prod_rnd = prod + 34'd32768;
  assign th       = twist_angle[16] ? -$signed({1'b0, prod_rnd[32:16]})
                                    : $signed({1'b0, prod_rnd[32:16]});

  always_ff @(posedge clk) begin
    if (adv) begin
      car[0] <= entry;
      p2     <= pp[32:16];
      prod   <= 34'(amag) * 34'(p2);
      t_r[0] <= {th, 16'b0};
    end
  end

  // bring the angle into [-pi, pi]
  for (genvar r = 0; r < 3; r++) begin : g_reduce
    always_ff @(posedge clk) begin
      if (adv) begin
        priority if (t_r[r] > twc_pkg::Q28_PI) begin
          t_r[r+1] <= t_r[r] - twc_pkg::Q28_TWO_PI;
        end else if (t_r[r] < -twc_pkg::Q28_PI) begin
          t_r[r+1] <= t_r[r] + twc_pkg::Q28_TWO_PI;
        end else begin
          t_r[r+1] <= t_r[r];
        end
      end
    end
  end

  // fold into [-pi/2, pi/2] and negate the results later
  always_comb begin
    priority if (t_r[3] > twc_pkg::Q28_HALF_PI) begin
      zf   = t_r[3] - twc_pkg::Q28_PI;
      negf = 1'b1;
    end else if (t_r[3] < -twc_pkg::Q28_HALF_PI) begin
      zf   = t_r[3] + twc_pkg::Q28_PI;
      negf = 1'b1;
    end else begin
      zf   = t_r[3];
      negf = 1'b0;
    end
    fold     = car[ST_FOLD-1];
    fold.neg = negf;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cxr[0] <= twc_pkg::Q28_GAIN;
      cyr[0] <= '0;
      czr[0] <= zf[31:0];
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv) begin
        car[k] <= (k == ST_FOLD) ? fold : car[k-1];
      end
    end
  end

  for (genvar g = 0; g < I; g++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!czr[g][31]) begin
          cxr[g+1] <= cxr[g] - (cyr[g] >>> g);
          cyr[g+1] <= cyr[g] + (cxr[g] >>> g);
          czr[g+1] <= czr[g] - twc_pkg::atan_q28(g);
        end else begin
          cxr[g+1] <= cxr[g] + (cyr[g] >>> g);
          cyr[g+1] <= cyr[g] - (cxr[g] >>> g);
          czr[g+1] <= czr[g] + twc_pkg::atan_q28(g);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_q <= to_q14(cxr[I], car[ST_Q14-1].neg);
      sin_q <= to_q14(cyr[I], car[ST_Q14-1].neg);
      m_dxc <= 33'(car[ST_MUL-1].fc.dx) * 33'(cos_q);
      m_dys <= 33'(car[ST_MUL-1].fc.dy) * 33'(sin_q);
      m_dxs <= 33'(car[ST_MUL-1].fc.dx) * 33'(sin_q);
      m_dyc <= 33'(car[ST_MUL-1].fc.dy) * 33'(cos_q);
      if (car[ST_XY-1].fc.in_radius) begin
        pos_x <= 35'($signed({1'b0, center_x, 14'b0})) + 35'(m_dxc) - 35'(m_dys);
        pos_y <= 35'($signed({1'b0, center_y, 14'b0})) + 35'(m_dxs) + 35'(m_dyc);
      end else begin
        pos_x <= 35'($signed({1'b0, car[ST_XY-1].fc.pixel_x, 18'b0}));
        pos_y <= 35'($signed({1'b0, car[ST_XY-1].fc.pixel_y, 18'b0}));
      end
      out_x  <= round_clamp(pos_x, image_width);
      out_y  <= round_clamp(pos_y, image_height);
      out_tw <= car[ST_XY].fc.in_radius;
    end
  end

  assign pix_out.valid       = vld[DEPTH-1];
  assign pix_out.source_x    = out_x;
  assign pix_out.source_y    = out_y;
  assign pix_out.was_twisted = out_tw;

endmodule

[design/twirl_coordinate_warp.sv]
// Twirl coordinate warp top level: configuration registers, front, queue, back.
// Depends on twc_pkg, twc_if, twc_front, twc_queue, twc_back.
//
//  port      | dir | fields
//  pix_in    | in  | pixel_x, pixel_y (destination pixel)
//  pix_out   | out | source_x, source_y, was_twisted
//  cfg_*     | in  | cfg_write, cfg_index, cfg_data (write only)
//
// One pixel per cycle sustained while the output is not stalled. The front
// holds the square root and divider stages, the back the CORDIC stages. rst
// is synchronous and clears all control state and loads the register
// defaults. A stalled output holds the back pipeline; the four-entry queue
// lets the front keep taking pixels until it fills.
module twirl_coordinate_warp #(
  parameter int unsigned MAX_DIM      = 4096,
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  twc_in_if.sink      pix_in,
  twc_out_if.source   pix_out,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  logic [12:0]        image_width, image_height;
  logic [15:0]        center_x, center_y, radius;
  logic signed [16:0] twist_angle;
  twc_pkg::q_push_t   q_wr;
  twc_pkg::q_head_t   q_head;
  logic               q_full, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd4096;
      image_height <= 13'd4096;
      center_x     <= 16'd32768;
      center_y     <= 16'd32768;
      radius       <= 16'd32768;
      twist_angle  <= 17'sd12868;
    end else if (cfg_write) begin
      unique case (twc_pkg::reg_index_t'(cfg_index))
        twc_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        twc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        twc_pkg::REG_CENTER_X:     center_x     <= cfg_data[15:0];
        twc_pkg::REG_CENTER_Y:     center_y     <= cfg_data[15:0];
        twc_pkg::REG_RADIUS:       radius       <= cfg_data[15:0];
        twc_pkg::REG_TWIST_ANGLE:  twist_angle  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  twc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  twc_queue #(.DEPTH(4)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .pop  (q_pop),
    .full (q_full),
    .head (q_head)
  );

  twc_back #(.MAX_DIM(MAX_DIM), .CORDIC_ITERS(CORDIC_ITERS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .pop          (q_pop),
    .image_width  (image_width),
    .image_height (image_height),
    .center_x     (center_x),
    .center_y     (center_y),
    .twist_angle  (twist_angle),
    .pix_out      (pix_out)
  );

endmodule

[design/twc_checker.sv]
// Port-level checks for the twirl coordinate warp, bound to the top level.
// Depends on twirl_coordinate_warp_defines.svh.
`include "twirl_coordinate_warp_defines.svh"

module twc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] source_x,
  input logic [11:0] source_y,
  input logic        was_twisted
);
  logic        out_stall;
  logic [24:0] result;

  assign out_stall = out_valid && !out_ready;
  assign result    = {source_x, source_y, was_twisted};

  `TWC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(result), "stalled result changed")
  `TWC_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result shown after reset")
  `TWC_ASSERT(a_stall_cause, !in_ready |-> $past(out_stall), "request refused without stall")
  `TWC_ASSERT_RST(a_reset_ready, rst |=> in_ready, "request refused after reset")

endmodule

bind twirl_coordinate_warp twc_checker u_twc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pix_in.ready),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .source_x    (pix_out.source_x),
  .source_y    (pix_out.source_y),
  .was_twisted (pix_out.was_twisted)
);
